// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, codes and control types of the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int POS_W   = 8;
  localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int GROUP   = 8;
  localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_GATHER = 1'b1
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic             insert;
    logic             get;
    logic [POS_W-1:0] pos;
  } chain_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list held in a chain of cells: insert at position, get at position,
// clear. One result per command, reporting status, read value and length.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   s_tvalid_i/s_tready_o  op, position, value
//  m_axis    out  m_tvalid_o/m_tready_i  status, read_value, length
//
//  Insert, clear, no-op and rejected commands: result registered in the cycle
//  after the transfer. Valid get: group gather registered, then final OR registered.
//  One command in flight; s_tready_o is low during a gather and while an
//  unaccepted result blocks the output register.
//  Reset clears the count and handshake state; cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [47:0] s_tdata_i,  // operation[1:0], position[9:2], value[41:10]
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic      [47:0] m_tdata_o   // status[1:0], read_value[33:2], length[40:34]
);

  localparam int DW = ple_pkg::DATA_WIDTH;
  localparam int CW = ple_pkg::CMP_W;

  ple_pkg::state_e                state_q, state_d;
  logic [ple_pkg::CNT_W-1:0]      count_q, count_d;
  logic                           out_valid_q, out_valid_d;
  logic [ple_pkg::ST_W-1:0]       status_q, status_d;
  logic [ple_pkg::VAL_W-1:0]      rdata_q, rdata_d;
  logic [ple_pkg::LEN_W-1:0]      len_q, len_d;

  logic [ple_pkg::OP_W-1:0]  op;
  logic [ple_pkg::POS_W-1:0] pos;
  logic [ple_pkg::VAL_W-1:0] value;
  logic [CW-1:0]             pos_w, cnt_w;
  logic [DW-1:0]             ins_data, chain_rdata;
  logic [63:0]               rdata_ext;
  logic                      xfer, ins_ok, get_ok;
  ple_pkg::chain_ctrl_t      chain_ctrl;

  assign op    = s_tdata_i[1:0];
  assign pos   = s_tdata_i[9:2];
  assign value = s_tdata_i[41:10];

  assign pos_w     = CW'(pos);
  assign cnt_w     = CW'(count_q);
  assign ins_data  = DW'(64'(value));
  assign rdata_ext = 64'(chain_rdata);

  assign s_tready_o = (state_q == ple_pkg::S_IDLE) && (!out_valid_q || m_tready_i);
  assign xfer       = s_tvalid_i && s_tready_o;

  assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + CW'(1))
                  && (count_q < ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign get_ok = (pos_w != '0) && (pos_w <= cnt_w);

  assign chain_ctrl.insert = xfer && (op == ple_pkg::OP_INSERT) && ins_ok;
  assign chain_ctrl.get    = xfer && (op == ple_pkg::OP_GET) && get_ok;
  assign chain_ctrl.pos    = pos;

  ple_chain u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (chain_ctrl),
    .ins_i   (ins_data),
    .rdata_o (chain_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_tready_i;
    status_d    = status_q;
    rdata_d     = rdata_q;
    len_d       = len_q;
    case (state_q)
      ple_pkg::S_IDLE: begin
        if (xfer) begin
          status_d = ple_pkg::STAT_OK;
          rdata_d  = '0;
          case (op)
            ple_pkg::OP_INSERT: begin
              if ((pos_w == '0) || (pos_w > cnt_w + CW'(1))) begin
                status_d = ple_pkg::STAT_BADPOS;
              end else if (!ins_ok) begin
                status_d = ple_pkg::STAT_FULL;
              end else begin
                count_d = count_q + ple_pkg::CNT_W'(1);
              end
            end
            ple_pkg::OP_GET: begin
              if (!get_ok) begin
                status_d = ple_pkg::STAT_BADPOS;
              end
            end
            ple_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
          len_d = ple_pkg::LEN_W'(count_d);
          if (chain_ctrl.get) begin
            state_d = ple_pkg::S_GATHER;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ple_pkg::S_GATHER: begin
        rdata_d     = rdata_ext[31:0];
        out_valid_d = 1'b1;
        state_d     = ple_pkg::S_IDLE;
      end
      default: begin
        state_d = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rdata_q  <= rdata_d;
    len_q    <= len_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {7'd0, len_q, rdata_q, status_q};

endmodule

`default_nettype wire

// ===== rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One list element: loads the inserted value or takes its neighbour's value.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell (
  input  wire logic                          clk_i,
  input  wire ple_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic [ple_pkg::DATA_WIDTH-1:0] prev_i,
  input  wire logic [ple_pkg::DATA_WIDTH-1:0] ins_i,
  output logic      [ple_pkg::DATA_WIDTH-1:0] data_o
);

  logic [ple_pkg::DATA_WIDTH-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= ins_i;
    end else if (ctrl_i.shift) begin
      data_q <= prev_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/ple_chain.sv =====
// ----------------------------------------------------------------------------
// ple_chain
// Row of list cells with per-cell shift/load decode and a two-level read
// gather: group ORs registered on a get, final OR taken the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_chain (
  input  wire logic                           clk_i,
  input  wire ple_pkg::chain_ctrl_t           ctrl_i,
  input  wire logic [ple_pkg::DATA_WIDTH-1:0] ins_i,
  output logic      [ple_pkg::DATA_WIDTH-1:0] rdata_o
);

  localparam int DW = ple_pkg::DATA_WIDTH;
  localparam int CW = ple_pkg::CMP_W;

  logic [DW-1:0] cell_data [ple_pkg::CAPACITY];
  logic [DW-1:0] group_d   [ple_pkg::NGROUPS];
  logic [DW-1:0] group_q   [ple_pkg::NGROUPS];
  logic [CW-1:0] pos_w;

  assign pos_w = CW'(ctrl_i.pos);

  for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
    ple_pkg::cell_ctrl_t cctl;
    logic [DW-1:0]       prev;

    assign cctl.load  = ctrl_i.insert && (pos_w == CW'(i + 1));
    assign cctl.shift = ctrl_i.insert && (CW'(i + 1) > pos_w);

    if (i == 0) begin : g_head
      assign prev = ins_i;
    end else begin : g_body
      assign prev = cell_data[i-1];
    end

    ple_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cctl),
      .prev_i (prev),
      .ins_i  (ins_i),
      .data_o (cell_data[i])
    );
  end

  always_comb begin
    for (int g = 0; g < ple_pkg::NGROUPS; g++) begin
      group_d[g] = '0;
      for (int j = 0; j < ple_pkg::GROUP; j++) begin
        if ((g * ple_pkg::GROUP + j) < ple_pkg::CAPACITY) begin
          if (pos_w == CW'(g * ple_pkg::GROUP + j + 1)) begin
            group_d[g] = group_d[g] | cell_data[g * ple_pkg::GROUP + j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.get) begin
      for (int g = 0; g < ple_pkg::NGROUPS; g++) begin
        group_q[g] <= group_d[g];
      end
    end
  end

  always_comb begin
    rdata_o = '0;
    for (int g = 0; g < ple_pkg::NGROUPS; g++) begin
      rdata_o = rdata_o | group_q[g];
    end
  end

endmodule

`default_nettype wire
